>>> rtl/b64_pkg.sv
`timescale 1ns / 1ps

package b64_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LINE_W     = 10;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW   = $clog2(QUEUE_DEPTH);

  localparam logic [LINE_W-1:0] LINE_LEN_RESET = 10'd76;
  localparam logic [BYTE_W-1:0] PAD_CHAR       = 8'h3D;
  localparam logic [BYTE_W-1:0] NL_CHAR        = 8'h0A;

  localparam logic [2:0] POS_C0 = 3'd0;
  localparam logic [2:0] POS_C1 = 3'd1;
  localparam logic [2:0] POS_C2 = 3'd2;
  localparam logic [2:0] POS_C3 = 3'd3;
  localparam logic [2:0] POS_NL = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [1:0]        cnt;
    logic              nl;
  } group_t;

  function automatic logic [BYTE_W-1:0] b64_sym(input logic [5:0] v);
    logic [BYTE_W-1:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

>>> rtl/b64_front.sv
`timescale 1ns / 1ps

module b64_front import b64_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              final_byte,
  input  logic [LINE_W-1:0] line_length,
  output logic              push,
  output group_t            push_grp
);

  logic [BYTE_W-1:0] held0_r, held0_nxt;
  logic [BYTE_W-1:0] held1_r, held1_nxt;
  logic [1:0]        held_cnt_r, held_cnt_nxt;
  logic [LINE_W-1:0] col_r, col_nxt;
  logic [LINE_W:0]   advanced;
  logic              collect;

  assign collect  = !final_byte && (held_cnt_r < 2'd2);
  assign advanced = {1'b0, col_r} + (LINE_W+1)'(4);
  assign push     = accept && !collect;

  always_comb begin
    push_grp.b0  = data_byte;
    push_grp.b1  = '0;
    push_grp.b2  = '0;
    push_grp.cnt = held_cnt_r + 2'd1;
    push_grp.nl  = advanced >= {1'b0, line_length};
    if (held_cnt_r == 2'd1) begin
      push_grp.b0 = held0_r;
      push_grp.b1 = data_byte;
    end else if (held_cnt_r != 2'd0) begin
      push_grp.b0 = held0_r;
      push_grp.b1 = held1_r;
      push_grp.b2 = data_byte;
    end
  end

  always_comb begin
    held0_nxt    = held0_r;
    held1_nxt    = held1_r;
    held_cnt_nxt = held_cnt_r;
    col_nxt      = col_r;
    if (accept) begin
      if (collect) begin
        if (held_cnt_r == 2'd0) begin
          held0_nxt = data_byte;
        end else begin
          held1_nxt = data_byte;
        end
        held_cnt_nxt = held_cnt_r + 2'd1;
      end else begin
        held_cnt_nxt = '0;
        if (push_grp.nl || final_byte) begin
          col_nxt = '0;
        end else begin
          col_nxt = advanced[LINE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    held0_r <= held0_nxt;
    held1_r <= held1_nxt;
    if (!rst_n) begin
      held_cnt_r <= '0;
      col_r      <= '0;
    end else begin
      held_cnt_r <= held_cnt_nxt;
      col_r      <= col_nxt;
    end
  end

endmodule

>>> rtl/b64_fifo.sv
`timescale 1ns / 1ps

module b64_fifo import b64_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  group_t push_grp,
  input  logic   pop,
  output group_t head_grp,
  output logic   empty,
  output logic   full
);

  group_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wptr_r, wptr_nxt;
  logic [QUEUE_AW-1:0]   rptr_r, rptr_nxt;
  logic [QUEUE_AW:0]     cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign empty    = cnt_r == '0;
  assign full     = cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign head_grp = mem_r[rptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wptr_nxt = do_push ? wptr_r + QUEUE_AW'(1) : wptr_r;
    rptr_nxt = do_pop ? rptr_r + QUEUE_AW'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (QUEUE_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (QUEUE_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_grp;
    end
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

>>> rtl/b64_back.sv
`timescale 1ns / 1ps

module b64_back import b64_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  group_t            head_grp,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_char,
  output logic              out_last
);

  logic [2:0]        pos_r, pos_nxt;
  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] char_r, char_nxt;
  logic              last_r, last_nxt;
  logic              load, advance;
  logic [BYTE_W-1:0] cur_char;
  logic              cur_last;

  assign load      = !valid_r || out_ready;
  assign advance   = load && head_valid;
  assign out_valid = valid_r;
  assign out_char  = char_r;
  assign out_last  = last_r;

  always_comb begin
    unique case (pos_r)
      POS_C0:  cur_char = b64_sym(head_grp.b0[7:2]);
      POS_C1:  cur_char = b64_sym({head_grp.b0[1:0], head_grp.b1[7:4]});
      POS_C2:  cur_char = (head_grp.cnt > 2'd1) ?
                          b64_sym({head_grp.b1[3:0], head_grp.b2[7:6]}) : PAD_CHAR;
      POS_C3:  cur_char = (head_grp.cnt > 2'd2) ? b64_sym(head_grp.b2[5:0]) : PAD_CHAR;
      default: cur_char = NL_CHAR;
    endcase
    cur_last = ((pos_r == POS_C3) && !head_grp.nl) || (pos_r == POS_NL);
  end

  assign pop = advance && cur_last;

  always_comb begin
    pos_nxt   = pos_r;
    valid_nxt = valid_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = head_valid;
    end
    if (advance) begin
      char_nxt = cur_char;
      last_nxt = cur_last;
      pos_nxt  = cur_last ? POS_C0 : pos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
    if (!rst_n) begin
      pos_r   <= POS_C0;
      valid_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

>>> rtl/base64_stream_encoder.sv
`timescale 1ns / 1ps
// channel | dir | handshake              | payload
// in_     | in  | in_tvalid / in_tready  | tdata: data_byte; tlast: final_byte
// out_    | out | out_tvalid / out_tready| tdata: out_char; tlast: last_of_run
// cfg_    | in  | cfg_valid / cfg_ready  | cfg_data: line_length
//
// A byte is taken in any cycle in which the queue is not full; a finished group
// leaves as 4 or 5 characters, one per cycle from the output register while
// out_tready is high. The character serializer limits throughput; a 4-group
// queue sits ahead of it. in_tready drops only while the queue is full;
// out_tready stalls the back, and the front only once the queue has filled.
// Synchronous reset clears held count, column, queue and output; line_length = 76.
module base64_stream_encoder import b64_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,   // [7:0] data_byte
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata,  // [7:0] out_char
  output logic              out_tlast,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LINE_W-1:0] cfg_data
);

  logic [LINE_W-1:0] line_len_r;
  logic              push, pop, empty, full;
  group_t            push_grp, head_grp;

  assign cfg_ready = 1'b1;
  assign in_tready = !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r <= LINE_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      line_len_r <= cfg_data;
    end
  end

  b64_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_tvalid && in_tready),
    .data_byte   (in_tdata),
    .final_byte  (in_tlast),
    .line_length (line_len_r),
    .push        (push),
    .push_grp    (push_grp)
  );

  b64_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .head_grp (head_grp),
    .empty    (empty),
    .full     (full)
  );

  b64_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_grp   (head_grp),
    .head_valid (!empty),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_char   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

>>> rtl/b64_checker.sv
`timescale 1ns / 1ps

module b64_checker import b64_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [BYTE_W-1:0] out_tdata,
  input logic              out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output request changed while stalled");

  a_nl_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == NL_CHAR |-> out_tlast)
    else $error("newline not marked last of run");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind base64_stream_encoder b64_checker u_b64_checker (.*);

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench import b64_pkg::*;;

  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned MAX_GAP       = 16;

  class char_scoreboard;
    localparam string ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct {
      logic [BYTE_W-1:0] ch;
      logic              last;
    } char_t;

    logic [LINE_W-1:0] line_len;
    logic [BYTE_W-1:0] held [2];
    int unsigned       held_n;
    logic [LINE_W-1:0] column;
    char_t             chars_due [$];
    int unsigned       mismatches;

    function new();
      line_len   = LINE_LEN_RESET;
      held[0]    = '0;
      held[1]    = '0;
      held_n     = 0;
      column     = '0;
      mismatches = 0;
    endfunction

    function logic [BYTE_W-1:0] sym(input logic [5:0] v);
      return ALPHABET[v];
    endfunction

    function void push_char(input logic [BYTE_W-1:0] c);
      char_t e;
      e.ch   = c;
      e.last = 1'b0;
      chars_due.push_back(e);
    endfunction

    function void note_byte(input logic [BYTE_W-1:0] d, input logic fin);
      logic [BYTE_W-1:0] b0, b1, b2;
      int unsigned       n;
      int unsigned       advanced;
      if (!fin && held_n < 2) begin
        held[held_n] = d;
        held_n++;
        return;
      end
      n  = held_n + 1;
      b0 = (held_n == 0) ? d : held[0];
      b1 = (held_n == 0) ? 8'h00 : ((held_n == 1) ? d : held[1]);
      b2 = (held_n == 2) ? d : 8'h00;
      push_char(sym(b0[7:2]));
      push_char(sym({b0[1:0], b1[7:4]}));
      push_char((n > 1) ? sym({b1[3:0], b2[7:6]}) : PAD_CHAR);
      push_char((n > 2) ? sym(b2[5:0]) : PAD_CHAR);
      held_n  = 0;
      held[0] = '0;
      held[1] = '0;
      advanced = int'(column) + 4;
      if (advanced >= int'(line_len)) begin
        push_char(NL_CHAR);
        column = '0;
      end else begin
        column = advanced[LINE_W-1:0];
      end
      if (fin) column = '0;
      chars_due[chars_due.size()-1].last = 1'b1;
    endfunction

    function void report(input string what, input logic [BYTE_W-1:0] ech, input logic el,
                         input logic [BYTE_W-1:0] ach, input logic al);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected char %h last %b, got char %h last %b", what, ech, el, ach, al);
    endfunction

    function void check_char(input logic [BYTE_W-1:0] c, input logic l);
      char_t e;
      if (chars_due.size() == 0) begin
        report("unexpected character", 8'hxx, 1'bx, c, l);
        return;
      end
      e = chars_due.pop_front();
      if (e.ch !== c || e.last !== l)
        report("character mismatch", e.ch, e.last, c, l);
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [BYTE_W-1:0] in_tdata   = '0;
  logic              in_tlast   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [BYTE_W-1:0] out_tdata;
  logic              out_tlast;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [LINE_W-1:0] cfg_data   = '0;

  char_scoreboard board = new();
  bit             tx_idle = 1'b1;
  bit             rx_idle = 1'b1;
  bit             rx_hold = 1'b0;
  int unsigned    quiet_cycles = 0;

  always #5 clk = ~clk;

  base64_stream_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no request accepted for %0d cycles", quiet_cycles);
      $display("testbench failed");
      $finish;
    end
  end

  function automatic int unsigned next_gap();
    return tx_idle ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] d, input logic fin, input int unsigned gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    board.note_byte(d, fin);
    @(negedge clk);
  endtask

  task automatic send_msg(input logic [BYTE_W-1:0] msg [$]);
    foreach (msg[k]) send_byte(msg[k], k == msg.size() - 1, next_gap());
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.chars_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_line_length(input logic [LINE_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    board.line_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned n_bytes, input int unsigned max_len);
    int unsigned sent;
    int unsigned len;
    bit          ends;
    sent = 0;
    while (sent < n_bytes) begin
      len  = $urandom_range(1, max_len);
      ends = ($urandom_range(0, 7) != 0);
      if ($urandom_range(0, 3) == 0) tx_idle = !tx_idle;
      for (int unsigned k = 0; k < len; k++)
        send_byte(pick_byte(), ends && (k == len - 1), next_gap());
      sent += len;
    end
  endtask

  initial begin
    int unsigned stall;
    while (!rst_n) @(negedge clk);
    forever begin
      if (rx_hold) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
      end
      stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      board.check_char(out_tdata, out_tlast);
      if ($urandom_range(0, 31) == 0) rx_idle = !rx_idle;
      @(negedge clk);
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_msg('{8'h00});
    send_msg('{8'hFF, 8'h00});
    send_msg('{8'hFF, 8'hFF, 8'hFF});
    send_msg('{8'hFB, 8'hEF, 8'hBE});

    set_line_length(10'd0);
    send_msg('{8'h4D, 8'h61, 8'h6E, 8'h80});

    // leave the line at column 12, then lower the length below it
    set_line_length(10'd1020);
    for (int k = 0; k < 9; k++) send_byte(pick_byte(), 1'b0, next_gap());
    set_line_length(10'd8);
    for (int k = 0; k < 3; k++) send_byte(pick_byte(), 1'b0, next_gap());
    send_msg('{8'h3C, 8'hC3});

    set_line_length(10'd76);
    random_phase(90, 70);
    set_line_length(10'd0);
    random_phase(40, 8);
    set_line_length(10'd1);
    random_phase(30, 8);
    set_line_length(10'd4);
    random_phase(30, 10);

    // fill the block while the receiver holds off
    rx_hold = 1'b1;
    for (int k = 0; k < 40; k++) send_byte(pick_byte(), k == 39, 0);
    drain();

    set_line_length(10'd7);
    random_phase(40, 16);
    set_line_length(10'd12);
    random_phase(50, 20);
    set_line_length(10'd1020);
    random_phase(40, 30);
    set_line_length(LINE_W'($urandom_range(0, 40)));
    random_phase(50, 30);
    set_line_length(10'd16);
    random_phase(40, 24);

    drain();
    if (board.mismatches == 0 && board.chars_due.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
